/* sv/fls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_pkg: shared types and constants for the frame luma statistics gate
// Holds the frame-size, colour-set and pixel-count constants, the word passed
// from the front part to the back part through the queue, and the state enum.
// ----------------------------------------------------------------------------
package fls_pkg;

	localparam int unsigned ExpectedWidth  = 2048;
	localparam int unsigned ExpectedHeight = 2048;
	localparam int unsigned ColourCap      = 4096;
	localparam int unsigned MaxPixels      = 4194304;
	localparam int unsigned SetSlots       = 2 * ColourCap;
	localparam int unsigned SlotW          = $clog2(SetSlots);
	localparam int unsigned CountW         = 23;
	localparam int unsigned ColourW        = 13;
	localparam logic [31:0] HashMul        = 32'd2654435761;
	localparam logic [7:0]  ClipLuma       = 8'd250;

	localparam logic [3:0] REG_ACTIVE_THRESHOLD = 4'd0;
	localparam logic [3:0] REG_MIN_PEAK         = 4'd1;
	localparam logic [3:0] REG_MIN_COLOURS      = 4'd2;
	localparam logic [3:0] REG_MEDIAN_LOW       = 4'd3;
	localparam logic [3:0] REG_MEDIAN_HIGH      = 4'd4;
	localparam logic [3:0] REG_UPPER_LOW        = 4'd5;
	localparam logic [3:0] REG_UPPER_HIGH       = 4'd6;
	localparam logic [3:0] REG_MIN_SPREAD       = 4'd7;

	// one queued word: a classified pixel
	typedef struct packed {
		logic        counted;
		logic        active;
		logic [7:0]  luma;
		logic [31:0] key;
		logic [SlotW-1:0] slot;
		logic        last;
		logic        size_ok;
	} pix_word_t;

	typedef enum logic [3:0] {
		B_IDLE, B_PROBE, B_CHECK, B_BIN_RD, B_BIN_WR,
		B_SWEEP, B_SWEEP_WAIT, B_JUDGE, B_CLEAR
	} back_state_t;

	typedef struct packed {
		logic [7:0]  active_threshold;
		logic [7:0]  min_peak_channel;
		logic [12:0] min_distinct_colours;
		logic [7:0]  median_low;
		logic [7:0]  median_high;
		logic [7:0]  upper_pct_low;
		logic [7:0]  upper_pct_high;
		logic [7:0]  min_luma_spread;
	} cfg_t;

endpackage

/* sv/frame_luma_statistics_gate_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_luma_statistics_gate_top: frame luma statistics and pass gate
// A pixel is taken when start is high and busy is low; busy then stays high
// until the back part has finished with it. Each accepted pixel is looked up
// in the 8192-slot colour set, with one extra linear probe per slot that holds
// another colour, and the lookup is skipped once the set holds 4096 colours;
// the colour and bin memories are single-ported with registered reads. A last
// pixel adds a bin sweep (read and clear, bin by bin) and a judgement state
// before done pulses for one cycle with the result; the receiver cannot stall
// it. After reset and after each result the block runs a clearing pass of the
// colour set and the bins with busy high.
// ----------------------------------------------------------------------------
module frame_luma_statistics_gate_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	input  logic        last_pixel,
	input  logic [14:0] frame_width,
	input  logic [14:0] frame_height,
	output logic [22:0] pixel_total,
	output logic [22:0] active_total,
	output logic [22:0] clipped_total,
	output logic [7:0]  pct05,
	output logic [7:0]  pct50,
	output logic [7:0]  pct95,
	output logic [8:0]  luma_spread,
	output logic [7:0]  peak_channel,
	output logic [12:0] distinct_colours,
	output logic        live_pass,
	output logic        bounds_pass
);

	fls_pkg::cfg_t      cfg_q;
	fls_pkg::pix_word_t fw, head;
	logic       take, push, pop, q_valid, back_busy, frame_done, hold_q;
	logic [1:0] fill;
	logic [22:0] pix_cnt;
	logic [7:0]  peak;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_threshold     <= 8'd8;
			cfg_q.min_peak_channel     <= 8'd64;
			cfg_q.min_distinct_colours <= 13'd64;
			cfg_q.median_low           <= 8'd35;
			cfg_q.median_high          <= 8'd210;
			cfg_q.upper_pct_low        <= 8'd100;
			cfg_q.upper_pct_high       <= 8'd248;
			cfg_q.min_luma_spread      <= 8'd35;
		end else if (cfg_we) begin
			case (cfg_index)
				fls_pkg::REG_ACTIVE_THRESHOLD: cfg_q.active_threshold <= cfg_data[7:0];
				fls_pkg::REG_MIN_PEAK:         cfg_q.min_peak_channel <= cfg_data[7:0];
				fls_pkg::REG_MIN_COLOURS:      cfg_q.min_distinct_colours <= cfg_data;
				fls_pkg::REG_MEDIAN_LOW:       cfg_q.median_low <= cfg_data[7:0];
				fls_pkg::REG_MEDIAN_HIGH:      cfg_q.median_high <= cfg_data[7:0];
				fls_pkg::REG_UPPER_LOW:        cfg_q.upper_pct_low <= cfg_data[7:0];
				fls_pkg::REG_UPPER_HIGH:       cfg_q.upper_pct_high <= cfg_data[7:0];
				fls_pkg::REG_MIN_SPREAD:       cfg_q.min_luma_spread <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// hold off intake after a last pixel until its result is out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (take && last_pixel) begin
			hold_q <= 1'b1;
		end else if (done) begin
			hold_q <= 1'b0;
		end
	end

	assign busy = back_busy || hold_q || (fill != 2'd0) || push;
	assign take = start && !busy;

	fls_front u_front (
		.clk, .arst_n, .take, .red, .green, .blue, .alpha, .last_pixel,
		.frame_width, .frame_height,
		.active_threshold(cfg_q.active_threshold),
		.frame_done, .push, .word(fw), .pixel_total(pix_cnt), .peak_channel(peak)
	);

	fls_queue u_queue (
		.clk, .arst_n, .push, .push_word(fw), .pop, .not_empty(q_valid), .fill,
		.head
	);

	fls_back u_back (
		.clk, .arst_n, .q_valid, .w(head), .cfg(cfg_q), .pixel_in(pix_cnt),
		.peak_in(peak), .pop, .busy(back_busy), .frame_done, .done,
		.pixel_total, .active_total, .clipped_total, .pct05, .pct50, .pct95,
		.luma_spread, .peak_channel, .distinct_colours, .live_pass, .bounds_pass
	);

endmodule

/* sv/fls_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_front: pixel intake and classification
// Computes luma, the active flag, the colour key and its hash slot, and keeps
// the pixel count and the channel peak. Pushes one word per pixel.
// ----------------------------------------------------------------------------
module fls_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [7:0]             red,
	input  logic [7:0]             green,
	input  logic [7:0]             blue,
	input  logic [7:0]             alpha,
	input  logic                   last_pixel,
	input  logic [14:0]            frame_width,
	input  logic [14:0]            frame_height,
	input  logic [7:0]             active_threshold,
	input  logic                   frame_done,
	output logic                   push,
	output fls_pkg::pix_word_t     word,
	output logic [22:0]            pixel_total,
	output logic [7:0]             peak_channel
);

	logic [16:0] luma_sum;
	logic [7:0]  luma;
	logic [7:0]  mx;
	logic [31:0] key;
	logic [63:0] hash_prod;
	logic [22:0] pix_q;
	logic [7:0]  peak_q;
	logic        counted;

	assign luma_sum = 17'(red) * 17'd54 + 17'(green) * 17'd183 + 17'(blue) * 17'd19;
	assign luma     = luma_sum[15:8];
	assign key      = {alpha, red, green, blue};
	assign hash_prod = 64'(key) * 64'(fls_pkg::HashMul);
	assign counted  = (32'(pix_q) < fls_pkg::MaxPixels);

	always_comb begin
		mx = (red > green) ? red : green;
		if (blue > mx) begin
			mx = blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q  <= '0;
			peak_q <= '0;
			push   <= 1'b0;
		end else begin
			push <= take;
			if (take) begin
				if (counted) begin
					pix_q <= pix_q + 23'd1;
				end
				if (mx > peak_q) begin
					peak_q <= mx;
				end
			end else if (frame_done) begin
				pix_q  <= '0;
				peak_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word.counted <= counted;
			word.active  <= counted && (luma > active_threshold);
			word.luma    <= luma;
			word.key     <= key;
			word.slot    <= hash_prod[fls_pkg::SlotW-1:0];
			word.last    <= last_pixel;
			word.size_ok <= (32'(frame_width) == fls_pkg::ExpectedWidth) &&
				(32'(frame_height) == fls_pkg::ExpectedHeight);
		end
	end

	assign pixel_total  = pix_q;
	assign peak_channel = peak_q;

endmodule

/* sv/fls_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_queue: two-entry queue between front and back parts
// Holds classified pixel words so each side may stall on its own.
// ----------------------------------------------------------------------------
module fls_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fls_pkg::pix_word_t push_word,
	input  logic               pop,
	output logic               not_empty,
	output logic [1:0]         fill,
	output fls_pkg::pix_word_t head
);

	fls_pkg::pix_word_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	assign not_empty = (cnt_q != 2'd0);
	assign fill      = cnt_q;
	assign head      = mem_q[rd_q];

	assert property (@(posedge clk) disable iff (!arst_n) !(pop && cnt_q == 2'd0))
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n) !(push && cnt_q == 2'd2 && !pop))
		else $error("queue pushed while full");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

/* sv/fls_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_back: histogram, colour set and frame judgement
// Does the bin read-modify-write per word and the linear-probe colour insert
// below the cap, sweeps the histogram on the last pixel, clears both memories.
// ----------------------------------------------------------------------------
module fls_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  fls_pkg::pix_word_t w,
	input  fls_pkg::cfg_t      cfg,
	input  logic [22:0]        pixel_in,
	input  logic [7:0]         peak_in,
	output logic               pop,
	output logic               busy,
	output logic               frame_done,
	output logic               done,
	output logic [22:0]        pixel_total,
	output logic [22:0]        active_total,
	output logic [22:0]        clipped_total,
	output logic [7:0]         pct05,
	output logic [7:0]         pct50,
	output logic [7:0]         pct95,
	output logic [8:0]         luma_spread,
	output logic [7:0]         peak_channel,
	output logic [12:0]        distinct_colours,
	output logic               live_pass,
	output logic               bounds_pass
);

	localparam int unsigned SW = fls_pkg::SlotW;

	fls_pkg::back_state_t st_q, st_d;

	// memories
	logic [22:0] bins_mem [256];
	logic [31:0] set_key_mem [fls_pkg::SetSlots];
	logic [0:0]  set_tag_mem [fls_pkg::SetSlots];
	logic [22:0] bin_rd_q;
	logic [31:0] key_rd_q;
	logic        tag_rd_q;
	logic        epoch_q;

	logic [SW-1:0] slot_q;
	logic [SW:0]   probes_q;
	logic [12:0]   colours_q;
	logic [8:0]    idx_q;
	logic [22:0]   act_q, clip_q, cum_q;
	logic [7:0]    p05_q, p50_q, p95_q;
	logic          f05_q, f50_q, f95_q;
	logic [29:0]   t05_q, t50_q, t95_q;
	logic          size_ok_q;

	logic          bin_we, set_we;
	logic [7:0]    bin_addr;
	logic [22:0]   bin_wdata;
	logic [SW-1:0] set_addr;
	logic          tag_wdata;
	logic [29:0]   cum100;
	logic [22:0]   cum_next;

	// memory ports: registered reads; bins are written zero during sweep and clear
	always_ff @(posedge clk) begin
		if (bin_we) begin
			bins_mem[bin_addr] <= bin_wdata;
		end
		bin_rd_q <= bins_mem[bin_addr];
		if (set_we) begin
			set_key_mem[set_addr] <= w.key;
			set_tag_mem[set_addr] <= tag_wdata;
		end
		key_rd_q <= set_key_mem[set_addr];
		tag_rd_q <= set_tag_mem[set_addr][0];
	end

	// the set uses an epoch bit: a slot is valid when its tag matches the epoch.
	// A clearing pass after reset and after each frame makes every tag differ
	// from the epoch.
	assign cum_next = cum_q + bin_rd_q;
	assign cum100   = 30'(cum_next) * 30'd100;

	always_comb begin
		st_d      = st_q;
		pop       = 1'b0;
		bin_we    = 1'b0;
		set_we    = 1'b0;
		bin_addr  = w.luma;
		bin_wdata = bin_rd_q + 23'd1;
		set_addr  = slot_q;
		tag_wdata = epoch_q;
		case (st_q)
			fls_pkg::B_CLEAR: begin
				set_we    = 1'b1;
				tag_wdata = ~epoch_q;
				bin_addr  = idx_q[7:0];
				bin_we    = 1'b1;
				bin_wdata = '0;
				if (idx_q == 9'd255 && probes_q == (SW+1)'(fls_pkg::SetSlots - 1)) begin
					st_d = fls_pkg::B_IDLE;
				end
			end
			fls_pkg::B_IDLE: begin
				set_addr = w.slot;
				if (q_valid) begin
					st_d = (colours_q < 13'(fls_pkg::ColourCap)) ? fls_pkg::B_PROBE
						: fls_pkg::B_BIN_RD;
				end
			end
			fls_pkg::B_PROBE: begin
				st_d = fls_pkg::B_CHECK;
			end
			fls_pkg::B_CHECK: begin
				if (tag_rd_q != epoch_q) begin
					set_we = 1'b1;
					st_d   = fls_pkg::B_BIN_RD;
				end else if (key_rd_q == w.key ||
					probes_q == (SW+1)'(fls_pkg::SetSlots - 1)) begin
					st_d = fls_pkg::B_BIN_RD;
				end else begin
					set_addr = slot_q + SW'(1);
					st_d     = fls_pkg::B_CHECK;
				end
			end
			fls_pkg::B_BIN_RD: begin
				st_d = fls_pkg::B_BIN_WR;
			end
			fls_pkg::B_BIN_WR: begin
				bin_we = w.active;
				pop    = 1'b1;
				st_d   = w.last ? fls_pkg::B_SWEEP : fls_pkg::B_IDLE;
			end
			fls_pkg::B_SWEEP: begin
				bin_addr = idx_q[7:0];
				st_d     = fls_pkg::B_SWEEP_WAIT;
			end
			fls_pkg::B_SWEEP_WAIT: begin
				bin_addr  = idx_q[7:0];
				bin_we    = 1'b1;
				bin_wdata = '0;
				st_d      = (idx_q == 9'd255) ? fls_pkg::B_JUDGE : fls_pkg::B_SWEEP;
			end
			fls_pkg::B_JUDGE: begin
				st_d = fls_pkg::B_CLEAR;
			end
			default: begin
				st_d = fls_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= fls_pkg::B_CLEAR;
			epoch_q   <= 1'b1;
			colours_q <= '0;
			idx_q     <= '0;
			probes_q  <= '0;
			slot_q    <= '0;
			act_q     <= '0;
			clip_q    <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				fls_pkg::B_CLEAR: begin
					idx_q    <= (idx_q == 9'd255) ? idx_q : idx_q + 9'd1;
					probes_q <= (probes_q == (SW+1)'(fls_pkg::SetSlots - 1)) ? probes_q
						: probes_q + (SW+1)'(1);
					slot_q   <= slot_q + SW'(1);
					if (st_d == fls_pkg::B_IDLE) begin
						idx_q <= '0;
					end
				end
				fls_pkg::B_IDLE: begin
					slot_q   <= w.slot;
					probes_q <= '0;
				end
				fls_pkg::B_CHECK: begin
					if (tag_rd_q != epoch_q) begin
						colours_q <= colours_q + 13'd1;
					end else if (!(key_rd_q == w.key ||
						probes_q == (SW+1)'(fls_pkg::SetSlots - 1))) begin
						slot_q   <= slot_q + SW'(1);
						probes_q <= probes_q + (SW+1)'(1);
					end
				end
				fls_pkg::B_BIN_WR: begin
					if (w.active) begin
						act_q <= act_q + 23'd1;
						if (w.luma >= fls_pkg::ClipLuma) begin
							clip_q <= clip_q + 23'd1;
						end
					end
					idx_q <= '0;
				end
				fls_pkg::B_SWEEP_WAIT: begin
					idx_q <= idx_q + 9'd1;
				end
				fls_pkg::B_JUDGE: begin
					act_q     <= '0;
					clip_q    <= '0;
					colours_q <= '0;
					epoch_q   <= ~epoch_q;
					idx_q     <= '0;
					probes_q  <= '0;
					slot_q    <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// percentile search: smallest v with 100*cum(v) > p*(active-1)
	always_ff @(posedge clk) begin
		if (st_q == fls_pkg::B_BIN_WR && w.last) begin
			cum_q     <= '0;
			f05_q     <= 1'b0;
			f50_q     <= 1'b0;
			f95_q     <= 1'b0;
			p05_q     <= 8'd255;
			p50_q     <= 8'd255;
			p95_q     <= 8'd255;
			size_ok_q <= w.size_ok;
			t05_q     <= 30'(act_q + 23'(w.active) - 23'd1) * 30'd5;
			t50_q     <= 30'(act_q + 23'(w.active) - 23'd1) * 30'd50;
			t95_q     <= 30'(act_q + 23'(w.active) - 23'd1) * 30'd95;
		end
		if (st_q == fls_pkg::B_SWEEP_WAIT) begin
			cum_q <= cum_next;
			if (!f05_q && cum100 > t05_q) begin
				f05_q <= 1'b1;
				p05_q <= idx_q[7:0];
			end
			if (!f50_q && cum100 > t50_q) begin
				f50_q <= 1'b1;
				p50_q <= idx_q[7:0];
			end
			if (!f95_q && cum100 > t95_q) begin
				f95_q <= 1'b1;
				p95_q <= idx_q[7:0];
			end
		end
	end

	logic        any_act;
	logic [7:0]  q05, q50, q95;
	logic [8:0]  spr;
	logic        live_c;

	assign any_act = (act_q != 23'd0);
	assign q05     = any_act ? p05_q : 8'd0;
	assign q50     = any_act ? p50_q : 8'd0;
	assign q95     = any_act ? p95_q : 8'd0;
	assign spr     = {1'b0, q95} - {1'b0, q05};
	assign live_c  = size_ok_q && (pixel_in != 23'd0) &&
		(29'(act_q) * 29'd50 >= 29'(pixel_in)) &&
		(peak_in >= cfg.min_peak_channel) &&
		(colours_q >= cfg.min_distinct_colours);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (st_q == fls_pkg::B_JUDGE);
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == fls_pkg::B_JUDGE) begin
			pixel_total      <= pixel_in;
			active_total     <= act_q;
			clipped_total    <= clip_q;
			pct05            <= q05;
			pct50            <= q50;
			pct95            <= q95;
			luma_spread      <= spr;
			peak_channel     <= peak_in;
			distinct_colours <= colours_q;
			live_pass        <= live_c;
			bounds_pass      <= live_c && any_act &&
				(29'(clip_q) * 29'd50 <= 29'(act_q)) &&
				(q50 >= cfg.median_low) && (q50 <= cfg.median_high) &&
				(q95 >= cfg.upper_pct_low) && (q95 <= cfg.upper_pct_high) &&
				!spr[8] && (spr[7:0] >= cfg.min_luma_spread);
		end
	end

	assign frame_done = (st_q == fls_pkg::B_JUDGE);
	assign busy = (st_q == fls_pkg::B_CLEAR) || (st_q == fls_pkg::B_SWEEP) ||
		(st_q == fls_pkg::B_SWEEP_WAIT) || (st_q == fls_pkg::B_JUDGE);

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_valid)
		else $error("pop without a queued word");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(st_q) == fls_pkg::B_JUDGE)
		else $error("result without judgement");
	assert property (@(posedge clk) disable iff (!arst_n) colours_q <= 13'(fls_pkg::ColourCap))
		else $error("colour count past cap");
	assert property (@(posedge clk) disable iff (!arst_n) clip_q <= act_q)
		else $error("clipped count above active count");

endmodule
